// ----- hdl/cst_pkg.sv -----
package cst_pkg;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } t_kind;

    // one result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_token;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [7:0] SEP_RESET = 8'h2C;

endpackage

// ----- hdl/csv_stream_tokenizer_top.sv -----
// Each result beat is written into the result queue as its byte is accepted; the output reads the
// queue head combinationally. Throughput: one input byte per cycle while the queue has room and
// bytes give at most one result each; a byte that gives two results (a record closed by stream
// end) writes both into the four-entry result queue, which accepts a byte whenever at least two
// entries are free. Reset (synchronous, active low): parser flags go to line start, queue empties,
// separator returns to ','.
module csv_stream_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_stream_end,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_field_byte,
    output logic       o_run_last,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_sep;
    logic       r_quoted, r_pending, r_line_start, r_comment;
    logic       n_quoted, n_pending, n_line_start, n_comment;

    cst_pkg::t_token r_queue [4];
    logic [1:0]      r_wr_ptr, r_rd_ptr;
    logic [2:0]      r_count;

    cst_pkg::t_token tok0, tok1;
    logic [1:0]      num_res;
    logic            in_accept, out_accept;
    logic            done;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_count > 3'd2);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign out_accept  = o_out_valid && !i_out_stall;

    // separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= cst_pkg::SEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sep <= i_cfg_data;
        end
    end

    // parse one byte into up to two results
    always_comb begin
        n_quoted     = r_quoted;
        n_pending    = r_pending;
        n_line_start = r_line_start;
        n_comment    = r_comment;
        num_res      = 2'd0;
        done         = 1'b0;
        tok0         = '{kind: cst_pkg::KIND_DATA, data: 8'd0, last: 1'b1};
        tok1         = '{kind: cst_pkg::KIND_RECORD, data: 8'd0, last: 1'b1};

        if (r_comment) begin
            if (i_text_byte == cst_pkg::CH_NL) begin
                n_comment    = 1'b0;
                n_line_start = 1'b1;
            end
        end else if (r_line_start && !r_quoted && i_text_byte == cst_pkg::CH_NL) begin
            // empty line dropped
        end else if (r_line_start && !r_quoted && i_text_byte == cst_pkg::CH_HASH) begin
            n_comment    = 1'b1;
            n_line_start = 1'b0;
        end else begin
            // resolve a pending quote first
            if (r_pending) begin
                n_pending = 1'b0;
                if (i_text_byte == cst_pkg::CH_QUOTE) begin
                    n_line_start = 1'b0;
                    tok0.kind    = cst_pkg::KIND_DATA;
                    tok0.data    = cst_pkg::CH_QUOTE;
                    num_res      = 2'd1;
                    done         = 1'b1;
                end else begin
                    n_quoted = !r_quoted;
                end
            end
            if (!done) begin
                n_line_start = 1'b0;
                if (i_text_byte == cst_pkg::CH_NL) begin
                    num_res = 2'd1;
                    if (n_quoted) begin
                        tok0.kind = cst_pkg::KIND_DATA;
                        tok0.data = cst_pkg::CH_NL;
                    end else begin
                        n_line_start = 1'b1;
                        tok0.kind    = cst_pkg::KIND_RECORD;
                    end
                end else if (!n_quoted && i_text_byte == r_sep) begin
                    num_res   = 2'd1;
                    tok0.kind = cst_pkg::KIND_FIELD;
                end else if (i_text_byte == cst_pkg::CH_QUOTE) begin
                    n_pending = 1'b1;
                end else begin
                    num_res   = 2'd1;
                    tok0.kind = cst_pkg::KIND_DATA;
                    tok0.data = i_text_byte;
                end
            end
        end

        // stream end closes an open line unless a quote stays open, and clears the parser
        if (i_stream_end) begin
            if (!n_comment && !n_line_start) begin
                if (n_pending) begin
                    n_quoted = !n_quoted;
                end
                if (!n_quoted) begin
                    if (num_res == 2'd0) begin
                        tok0.kind = cst_pkg::KIND_RECORD;
                        tok0.data = 8'd0;
                        num_res   = 2'd1;
                    end else begin
                        tok0.last = 1'b0;
                        num_res   = 2'd2;
                    end
                end
            end
            n_quoted     = 1'b0;
            n_pending    = 1'b0;
            n_line_start = 1'b1;
            n_comment    = 1'b0;
        end
    end

    // parser flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted     <= 1'b0;
            r_pending    <= 1'b0;
            r_line_start <= 1'b1;
            r_comment    <= 1'b0;
        end else if (in_accept) begin
            r_quoted     <= n_quoted;
            r_pending    <= n_pending;
            r_line_start <= n_line_start;
            r_comment    <= n_comment;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_accept && num_res != 2'd0) begin
            r_queue[r_wr_ptr] <= tok0;
        end
        if (in_accept && num_res == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= tok1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + num_res;
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_accept ? {1'b0, num_res} : 3'd0)
                       - {2'd0, out_accept};
        end
    end

    // output beat
    assign o_token_kind = r_queue[r_rd_ptr].kind;
    assign o_field_byte = r_queue[r_rd_ptr].data;
    assign o_run_last   = r_queue[r_rd_ptr].last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_stream_end |=>
            r_line_start && !r_quoted && !r_pending && !r_comment)
        else $error("parser not cleared after stream end");

    a_comment_unquoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comment |-> !r_quoted && !r_pending)
        else $error("comment line inside quotes");

    a_stall_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> r_count <= 3'd2)
        else $error("byte accepted without queue room");
`endif

endmodule

// ----- sim/csv_stream_tokenizer_top_test.sv -----
`timescale 1ns / 100ps

module csv_stream_tokenizer_top_test;

    typedef struct {
        logic [7:0] b;
        logic       fin;
    } t_text_beat;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_text_byte  = 8'h00;
    logic       i_stream_end = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic [7:0] i_cfg_data   = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_token_kind;
    logic [7:0] o_field_byte;
    logic       o_run_last;
    logic       o_cfg_ready;

    // bytes waiting to be driven, tokens waiting to come out
    t_text_beat      text_backlog[$];
    cst_pkg::t_token pending_tokens[$];
    cst_pkg::t_token step_tokens[$];

    // tokenizer state as predicted
    logic [7:0] sep_model  = cst_pkg::SEP_RESET;
    logic       in_quotes  = 1'b0;
    logic       quote_wait = 1'b0;
    logic       line_fresh = 1'b1;
    logic       in_comment = 1'b0;

    int              mismatch_count = 0;
    int              items_queued   = 0;
    bit              idle_on        = 1'b1;
    int              in_gap         = 0;
    int              stall_left     = 0;
    t_text_beat      nxt;
    cst_pkg::t_token exp_tok;

    csv_stream_tokenizer_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_text_byte  (i_text_byte),
        .i_stream_end (i_stream_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_token_kind (o_token_kind),
        .o_field_byte (o_field_byte),
        .o_run_last   (o_run_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void stage(cst_pkg::t_kind k, logic [7:0] d);
        cst_pkg::t_token tk;
        tk.kind = k;
        tk.data = d;
        tk.last = 1'b0;
        step_tokens.insert(step_tokens.size(), tk);
    endfunction

    // one byte seen by the field scanner, after line start handling
    task automatic absorb_byte(input logic [7:0] b);
        bit done;
        done = 1'b0;
        // a pending quote is settled by this byte
        if (quote_wait) begin
            quote_wait = 1'b0;
            if (b == cst_pkg::CH_QUOTE) begin
                line_fresh = 1'b0;
                stage(cst_pkg::KIND_DATA, cst_pkg::CH_QUOTE);
                done = 1'b1;
            end else begin
                in_quotes = !in_quotes;
            end
        end
        if (!done) begin
            line_fresh = 1'b0;
            if (b == cst_pkg::CH_NL) begin
                if (in_quotes) begin
                    stage(cst_pkg::KIND_DATA, cst_pkg::CH_NL);
                end else begin
                    line_fresh = 1'b1;
                    stage(cst_pkg::KIND_RECORD, 8'h00);
                end
            end else if (!in_quotes && b == sep_model) begin
                stage(cst_pkg::KIND_FIELD, 8'h00);
            end else if (b == cst_pkg::CH_QUOTE) begin
                quote_wait = 1'b1;
            end else begin
                stage(cst_pkg::KIND_DATA, b);
            end
        end
    endtask

    // expected tokens for one accepted byte
    task automatic tokenize_byte(input logic [7:0] b, input logic fin);
        step_tokens.delete();
        if (in_comment) begin
            if (b == cst_pkg::CH_NL) begin
                in_comment = 1'b0;
                line_fresh = 1'b1;
            end
        end else if (line_fresh && !in_quotes && b == cst_pkg::CH_NL) begin
            // empty line dropped
        end else if (line_fresh && !in_quotes && b == cst_pkg::CH_HASH) begin
            in_comment = 1'b1;
            line_fresh = 1'b0;
        end else begin
            absorb_byte(b);
        end
        // stream end closes an open line unless a quote stays open
        if (fin) begin
            if (!in_comment && !line_fresh) begin
                if (quote_wait) begin
                    quote_wait = 1'b0;
                    in_quotes  = !in_quotes;
                end
                if (!in_quotes) stage(cst_pkg::KIND_RECORD, 8'h00);
            end
            in_quotes  = 1'b0;
            quote_wait = 1'b0;
            line_fresh = 1'b1;
            in_comment = 1'b0;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
    endtask

    // input driver with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) tokenize_byte(i_text_byte, i_stream_end);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (text_backlog.size() > 0 && idle_on && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 8);
                    i_in_valid <= 1'b0;
                end else if (text_backlog.size() > 0) begin
                    nxt = text_backlog.pop_front();
                    i_text_byte  <= nxt.b;
                    i_stream_end <= nxt.fin;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_tokens.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected beat kind=%0d byte=%02h last=%0b",
                                 $realtime, o_token_kind, o_field_byte, o_run_last);
                end else begin
                    exp_tok = pending_tokens.pop_front();
                    if (o_token_kind !== exp_tok.kind || o_field_byte !== exp_tok.data ||
                        o_run_last !== exp_tok.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: beat mismatch exp kind=%0d byte=%02h last=%0b, %s",
                                     $realtime, exp_tok.kind, exp_tok.data, exp_tok.last,
                                     $sformatf("got kind=%0d byte=%02h last=%0b",
                                               o_token_kind, o_field_byte, o_run_last));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic fin);
        t_text_beat tb;
        tb.b   = b;
        tb.fin = fin;
        text_backlog.insert(text_backlog.size(), tb);
        items_queued++;
    endtask

    task automatic push_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], fin_last && i == s.len() - 1);
    endtask

    // field content byte that is neither separator, quote nor newline
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h61, 8'h7A));
            else b = 8'($urandom_range(0, 255));
        end while (b == sep_model || b == cst_pkg::CH_QUOTE || b == cst_pkg::CH_NL);
        return b;
    endfunction

    // one csv line: empty, comment, or a record of plain and quoted fields
    task automatic gen_line(input bit close_stream);
        int pick;
        int nf;
        int len;
        int r;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            add_byte(cst_pkg::CH_NL, 1'b0);
        end else if (pick == 1) begin
            add_byte(cst_pkg::CH_HASH, 1'b0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) add_byte(cst_pkg::CH_QUOTE, 1'b0);
                else add_byte(plain_byte(), 1'b0);
            end
            add_byte(cst_pkg::CH_NL, 1'b0);
        end else begin
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++) begin
                if (f > 0) add_byte(sep_model, 1'b0);
                len = $urandom_range(0, 5);
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(cst_pkg::CH_QUOTE, 1'b0);
                    for (int i = 0; i < len; i++) begin
                        r = $urandom_range(0, 5);
                        if (r == 0) begin
                            add_byte(cst_pkg::CH_QUOTE, 1'b0);
                            add_byte(cst_pkg::CH_QUOTE, 1'b0);
                        end else if (r == 1) begin
                            add_byte(cst_pkg::CH_NL, 1'b0);
                        end else if (r == 2) begin
                            add_byte(sep_model, 1'b0);
                        end else begin
                            add_byte(plain_byte(), 1'b0);
                        end
                    end
                    add_byte(cst_pkg::CH_QUOTE, 1'b0);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        r = $urandom_range(0, 7);
                        if (r == 0) begin
                            add_byte(cst_pkg::CH_QUOTE, 1'b0);
                            add_byte(cst_pkg::CH_QUOTE, 1'b0);
                        end else if (r == 1) begin
                            add_byte(8'h0D, 1'b0);
                        end else begin
                            add_byte(plain_byte(), 1'b0);
                        end
                    end
                end
            end
            if (!close_stream || $urandom_range(0, 1) == 0) add_byte(cst_pkg::CH_NL, 1'b0);
        end
        if (close_stream) text_backlog[text_backlog.size() - 1].fin = 1'b1;
    endtask

    // broken input: arbitrary bytes, stream ends anywhere
    task automatic gen_noise();
        int len;
        len = $urandom_range(3, 12);
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    endtask

    task automatic wait_drained();
        while (text_backlog.size() != 0 || i_in_valid || pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sep_model = v;
    endtask

    // stimulus sequence
    initial begin
        logic [7:0] sep_plan[7];
        int         phase_start;
        sep_plan = '{8'h00, 8'hFF, cst_pkg::CH_QUOTE, cst_pkg::CH_NL, cst_pkg::CH_HASH, 8'h00,
                     cst_pkg::SEP_RESET};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty line, comment, quoting cases, stream end cases
        push_text("\n", 1'b0);
        push_text("#x\n", 1'b0);
        push_text("a,\"b\"\"\n\",\r\n", 1'b0);
        push_text("\"\"q", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(cst_pkg::CH_QUOTE, 1'b1);
        add_byte(8'h00, 1'b1);
        push_text("\"x", 1'b1);
        wait_drained();

        // random phases, one separator setting each
        for (int p = 0; p < 7; p++) begin
            if (p == 5) write_separator(8'($urandom_range(0, 255)));
            else write_separator(sep_plan[p]);
            idle_on = (p != 3) && (p != 6);
            phase_start = items_queued;
            while (items_queued - phase_start < 75) begin
                if ($urandom_range(0, 9) < 8) gen_line($urandom_range(0, 5) == 0);
                else gen_noise();
            end
            gen_line(1'b1);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
